/* rtl/core/hpart_pkg.sv */
// Shared constants and widths of the hall pulse angle and rpm tracker.
// No dependencies; used by the divider and the top level by scoped names.
package hpart_pkg;

  // Sensor setup.
  localparam int PULSES_PER_TURN = 4;
  localparam int FILTER_DEPTH    = 8;

  // Fixed constants of the measurement.
  localparam int FULL_CIRCLE_DEG = 360;
  localparam int RPM_NUMERATOR   = 60000000;
  localparam int RPM_MAX         = 65535;

  // Field widths.
  localparam int TIME_W  = 32;
  localparam int ANGLE_W = 9;
  localparam int RPM_W   = 16;

  // Angle step per pulse.
  localparam int ANGLE_STEP = FULL_CIRCLE_DEG / PULSES_PER_TURN;

  // floor(floor(N/P)/i) equals floor(N/(P*i)), so the pulse count folds into the numerator.
  localparam int NUM_PER_PULSE = RPM_NUMERATOR / PULSES_PER_TURN;
  localparam int NUM_W         = $clog2(NUM_PER_PULSE + 1);

  // Moving average store.
  localparam int SUM_W  = $clog2(FILTER_DEPTH * RPM_MAX + 1);
  localparam int FILL_W = $clog2(FILTER_DEPTH + 1);
  localparam int POS_W  = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;

  // Shared divider sizing.
  localparam int DIV_W     = (NUM_W > SUM_W) ? NUM_W : SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

endpackage

/* rtl/core/hpart_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module hpart_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/hpart_divider.sv */
// Restoring divider, one quotient bit per cycle, shared by the rpm and average steps.
// Depends on hpart_pkg for operand widths.
module hpart_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [hpart_pkg::DIV_W-1:0]  dividend,
  input  logic [hpart_pkg::TIME_W-1:0] divisor,
  output logic                        done,
  output logic [hpart_pkg::DIV_W-1:0]  quotient
);

  logic                            busy;
  logic [hpart_pkg::DIV_CNT_W-1:0] cnt;
  logic [hpart_pkg::TIME_W-1:0]    rem;
  logic [hpart_pkg::TIME_W-1:0]    dsr;
  logic [hpart_pkg::TIME_W:0]      shifted;
  logic [hpart_pkg::TIME_W:0]      diff;
  logic                            fits;

  always_comb begin
    shifted = {rem, quotient[hpart_pkg::DIV_W-1]};
    diff    = shifted - {1'b0, dsr};
    fits    = (shifted >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= hpart_pkg::DIV_CNT_W'(hpart_pkg::DIV_W);
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        // Each step brings down one dividend bit and decides one quotient bit.
        if (fits) begin
          rem <= diff[hpart_pkg::TIME_W-1:0];
        end else begin
          rem <= shifted[hpart_pkg::TIME_W-1:0];
        end
        quotient <= {quotient[hpart_pkg::DIV_W-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == hpart_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/hall_pulse_angle_rpm_tracker_unit.sv */
// Hall pulse angle and rpm tracker: top level with the sequencer and filter state.
// A rising edge request is taken and dropped; the first falling edge goes straight to
// S_DONE; later falling edges pass through the 24-step divider twice (rpm, then average),
// or only once for the average when the interval is zero.
// One request at a time; a new request is taken while a finished result still waits in the
// output register. Reset clears angle, stamps, flag, sum, fill, position.
module hall_pulse_angle_rpm_tracker_unit (
  input  logic                         clk,
  input  logic                         rst,
  // Edge request channel.
  input  logic                         edge_valid,
  output logic                         edge_ready,
  input  logic                         falling_edge,
  input  logic [hpart_pkg::TIME_W-1:0]  edge_time_us,
  input  logic                         zero_sensor_level,
  // Result channel.
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [hpart_pkg::ANGLE_W-1:0] angle_base_deg,
  output logic [hpart_pkg::TIME_W-1:0]  angle_stamp_us,
  output logic                         rpm_valid,
  output logic [hpart_pkg::RPM_W-1:0]   rpm_average
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RPM_DIV,
    S_PUSH,
    S_AVG_DIV,
    S_DONE
  } state_t;

  state_t state;

  // Tracker state.
  logic [hpart_pkg::ANGLE_W-1:0] angle_reg;
  logic [hpart_pkg::TIME_W-1:0]  angle_time_reg;
  logic [hpart_pkg::TIME_W-1:0]  last_pulse_stamp;
  logic                          primed_flag;
  logic [hpart_pkg::SUM_W-1:0]   history_sum;
  logic [hpart_pkg::FILL_W-1:0]  history_fill;
  logic [hpart_pkg::POS_W-1:0]   history_write_pos;

  // Working values of the request in flight.
  logic [hpart_pkg::RPM_W-1:0]   rpm_sample;
  logic                          rpm_flag;
  logic [hpart_pkg::RPM_W-1:0]   avg_value;

  // Combinational next values.
  logic                          accept;
  logic [hpart_pkg::TIME_W-1:0]  interval;
  logic [hpart_pkg::ANGLE_W:0]   angle_sum;
  logic [hpart_pkg::ANGLE_W-1:0] angle_next;
  logic                          filter_full;
  logic [hpart_pkg::SUM_W-1:0]   history_sum_next;
  logic [hpart_pkg::FILL_W-1:0]  history_fill_next;
  logic [hpart_pkg::POS_W-1:0]   history_write_pos_next;
  logic [hpart_pkg::RPM_W-1:0]   oldest_sample;
  logic                          out_free;

  // Divider hookup.
  logic                          div_start;
  logic [hpart_pkg::DIV_W-1:0]   div_dividend;
  logic [hpart_pkg::TIME_W-1:0]  div_divisor;
  logic                          div_done;
  logic [hpart_pkg::DIV_W-1:0]   div_quotient;

  assign edge_ready = (state == S_IDLE);
  assign accept     = edge_valid && edge_ready;
  assign out_free   = !result_valid || result_ready;

  always_comb begin
    interval = edge_time_us - last_pulse_stamp;

    // The angle stays below 360, so one conditional subtract wraps it.
    angle_sum = {1'b0, angle_reg} + (hpart_pkg::ANGLE_W + 1)'(hpart_pkg::ANGLE_STEP);
    if (!zero_sensor_level) begin
      angle_next = '0;
    end else if (angle_sum >= (hpart_pkg::ANGLE_W + 1)'(hpart_pkg::FULL_CIRCLE_DEG)) begin
      angle_next = hpart_pkg::ANGLE_W'(angle_sum
                   - (hpart_pkg::ANGLE_W + 1)'(hpart_pkg::FULL_CIRCLE_DEG));
    end else begin
      angle_next = angle_sum[hpart_pkg::ANGLE_W-1:0];
    end

    // Once the filter is full the oldest sample leaves the sum.
    filter_full = (history_fill == hpart_pkg::FILL_W'(hpart_pkg::FILTER_DEPTH));
    if (filter_full) begin
      history_sum_next  = history_sum - hpart_pkg::SUM_W'(oldest_sample)
                          + hpart_pkg::SUM_W'(rpm_sample);
      history_fill_next = history_fill;
    end else begin
      history_sum_next  = history_sum + hpart_pkg::SUM_W'(rpm_sample);
      history_fill_next = history_fill + 1'b1;
    end
    if (history_write_pos == hpart_pkg::POS_W'(hpart_pkg::FILTER_DEPTH - 1)) begin
      history_write_pos_next = '0;
    end else begin
      history_write_pos_next = history_write_pos + 1'b1;
    end

    // The divider forms the rpm (unless the interval is zero), then the average of the stored samples.
    div_start    = 1'b0;
    div_dividend = hpart_pkg::DIV_W'(hpart_pkg::NUM_PER_PULSE);
    div_divisor  = interval;
    case (state)
      S_IDLE: begin
        div_start = accept && falling_edge && primed_flag && (interval != '0);
      end
      S_PUSH: begin
        div_start    = 1'b1;
        div_dividend = hpart_pkg::DIV_W'(history_sum_next);
        div_divisor  = hpart_pkg::TIME_W'(history_fill_next);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  hpart_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // The read address follows the write position, so the oldest sample is ready by S_PUSH.
  hpart_ram #(
    .WIDTH (hpart_pkg::RPM_W),
    .DEPTH (hpart_pkg::FILTER_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (state == S_PUSH),
    .waddr (history_write_pos),
    .wdata (rpm_sample),
    .raddr (history_write_pos),
    .rdata (oldest_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      angle_reg         <= '0;
      angle_time_reg    <= '0;
      last_pulse_stamp  <= '0;
      primed_flag       <= 1'b0;
      history_sum       <= '0;
      history_fill      <= '0;
      history_write_pos <= '0;
      result_valid      <= 1'b0;
    end else begin
      // In S_DONE the output register is reloaded below instead.
      if (result_valid && result_ready && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          // Rising edges are taken and dropped without a result.
          if (accept && falling_edge) begin
            angle_reg        <= angle_next;
            angle_time_reg   <= edge_time_us;
            last_pulse_stamp <= edge_time_us;
            primed_flag      <= 1'b1;
            rpm_flag         <= primed_flag;
            avg_value        <= '0;
            if (!primed_flag) begin
              state <= S_DONE;
            end else if (interval == '0) begin
              rpm_sample <= hpart_pkg::RPM_W'(hpart_pkg::RPM_MAX);
              state      <= S_PUSH;
            end else begin
              state <= S_RPM_DIV;
            end
          end
        end
        S_RPM_DIV: begin
          if (div_done) begin
            if (div_quotient > hpart_pkg::DIV_W'(hpart_pkg::RPM_MAX)) begin
              rpm_sample <= hpart_pkg::RPM_W'(hpart_pkg::RPM_MAX);
            end else begin
              rpm_sample <= div_quotient[hpart_pkg::RPM_W-1:0];
            end
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          history_sum       <= history_sum_next;
          history_fill      <= history_fill_next;
          history_write_pos <= history_write_pos_next;
          state             <= S_AVG_DIV;
        end
        S_AVG_DIV: begin
          if (div_done) begin
            avg_value <= div_quotient[hpart_pkg::RPM_W-1:0];
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          // Hand the result to the output register once it is free.
          if (out_free) begin
            result_valid   <= 1'b1;
            angle_base_deg <= angle_reg;
            angle_stamp_us <= angle_time_reg;
            rpm_valid      <= rpm_flag;
            rpm_average    <= avg_value;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
